// File: design/sorg_pkg.sv
package sorg_pkg;

  // Table size and the address width that follows from it.
  localparam int NUM_BUMPS = 16;
  localparam int IDX_W     = (NUM_BUMPS > 1) ? $clog2(NUM_BUMPS) : 1;

  // Item codes.
  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  // One table entry as it sits in the memory.
  typedef struct packed {
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic signed [15:0] cosine;
    logic signed [15:0] sine;
    logic [17:0]        inv_x;
    logic [17:0]        inv_y;
    logic signed [14:0] height;
  } bump_entry_t;

  localparam int ENTRY_W = $bits(bump_entry_t);

  // Write port from the load unit.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    bump_entry_t      entry;
  } tbl_wr_t;

  // Read side seen by the evaluate unit; live is low for a slot never loaded.
  typedef struct packed {
    logic        live;
    bump_entry_t entry;
  } tbl_rd_t;

  // One evaluate result.
  typedef struct packed {
    logic [15:0]        x;
    logic [15:0]        y;
    logic signed [18:0] height;
    logic               sat;
  } eval_res_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_SQUARE,
    L_SETUP,
    L_ITER,
    L_WRITE
  } load_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_ISSUE,
    E_DRAIN,
    E_DONE
  } eval_state_t;

  // Sine and cosine by rotation steps; angles in Q.16.
  localparam int                 CORDIC_STEPS = 16;
  localparam int                 DIV_STEPS    = 18;
  localparam logic signed [17:0] CORDIC_K     = 18'sd9949;
  localparam logic signed [17:0] ONE_Q14      = 18'sd16384;
  localparam logic signed [20:0] PI_Q16       = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_Q16  = 21'sd102944;
  localparam logic [17:0]        INV_MAX      = 18'h3FFFF;

  function automatic logic signed [20:0] atan_q16(input logic [3:0] i);
    logic signed [20:0] a;
    case (i)
      4'd0:    a = 21'sd51472;
      4'd1:    a = 21'sd30386;
      4'd2:    a = 21'sd16055;
      4'd3:    a = 21'sd8150;
      4'd4:    a = 21'sd4091;
      4'd5:    a = 21'sd2047;
      4'd6:    a = 21'sd1024;
      4'd7:    a = 21'sd512;
      4'd8:    a = 21'sd256;
      4'd9:    a = 21'sd128;
      4'd10:   a = 21'sd64;
      4'd11:   a = 21'sd32;
      4'd12:   a = 21'sd16;
      4'd13:   a = 21'sd8;
      4'd14:   a = 21'sd4;
      default: a = 21'sd2;
    endcase
    return a;
  endfunction

  // Exponential: ln2 in Q.26, its reciprocal scaled by 2^56, one in Q.30.
  localparam logic [29:0] LN2_Q26   = 30'd46516320;
  localparam logic [30:0] LN2_RECIP = 31'((64'd1 << 56) / 64'd46516320);
  localparam int          LN2_SHIFT = 56;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

  // Horner steps divide by 6, 5, 4, 3, 2, 1 through exact reciprocals.
  localparam int HORNER_STEPS = 6;
  localparam logic [31:0] HORNER_MUL [HORNER_STEPS] = '{
    32'(((64'd1 << 34) + 64'd5) / 64'd6),
    32'(((64'd1 << 34) + 64'd4) / 64'd5),
    32'((64'd1 << 32) / 64'd4),
    32'(((64'd1 << 33) + 64'd2) / 64'd3),
    32'((64'd1 << 32) / 64'd2),
    32'(64'd1 << 31)
  };
  localparam int HORNER_SHIFT [HORNER_STEPS] = '{34, 34, 32, 33, 32, 31};

  // Output range.
  localparam int SUM_MAX = 262143;
  localparam int SUM_MIN = -262144;

endpackage

// File: design/sorg_ram.sv
module sorg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sorg_load.sv
module sorg_load import sorg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [3:0]         bump_index,
  input  logic [15:0]        center_x,
  input  logic [15:0]        center_y,
  input  logic [14:0]        sigma_x,
  input  logic [14:0]        sigma_y,
  input  logic signed [14:0] peak_height,
  input  logic [14:0]        rotation,
  output logic               busy,
  output tbl_wr_t            wr
);

  load_state_t state, state_next;

  logic [4:0]             cnt;
  logic [IDX_W-1:0]       slot;
  logic                   skip;
  logic [15:0]            cx, cy;
  logic signed [14:0]     ht;
  logic [14:0]            sig_x, sig_y, rot;
  logic [29:0]            sq_x, sq_y;
  logic [29:0]            rem_x, rem_y;
  logic [17:0]            num_x, num_y;
  logic [17:0]            quo_x, quo_y;
  logic                   sat_x, sat_y;
  logic signed [17:0]     cor_x, cor_y;
  logic signed [20:0]     ang;
  logic                   flip;

  logic [IDX_W+3:0]       idx_ext;
  logic [37:0]            nf_x, nf_y;
  logic [30:0]            trial_x, trial_y;
  logic                   ge_x, ge_y;
  logic signed [20:0]     ang0;
  logic signed [17:0]     sh_x, sh_y;
  logic signed [15:0]     cl_x, cl_y;

  function automatic logic signed [15:0] clamp_unit(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > ONE_Q14) begin
      r = 16'sd16384;
    end else if (v < -ONE_Q14) begin
      r = -16'sd16384;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Slot decode; loads past the table are dropped.
  assign idx_ext = {{IDX_W{1'b0}}, bump_index};

  // Rounded numerator 2^37 + sq/2 for each inverse.
  assign nf_x = {1'b1, 37'b0} + {9'b0, sq_x[29:1]};
  assign nf_y = {1'b1, 37'b0} + {9'b0, sq_y[29:1]};

  // One restoring division step per cycle.
  assign trial_x = {rem_x, num_x[17]};
  assign trial_y = {rem_y, num_y[17]};
  assign ge_x    = trial_x >= {1'b0, sq_x};
  assign ge_y    = trial_y >= {1'b0, sq_y};

  // Starting angle, folded above a right angle.
  assign ang0 = {3'b0, rot, 3'b0};

  // Floor shifts of the rotation step.
  assign sh_x = cor_y >>> cnt[3:0];
  assign sh_y = cor_x >>> cnt[3:0];

  assign cl_x = clamp_unit(cor_x);
  assign cl_y = clamp_unit(cor_y);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and outputs.
  always_comb begin
    state_next = state;
    busy       = (state != L_IDLE);
    wr.we      = 1'b0;
    wr.addr    = slot;
    wr.entry.cx     = cx;
    wr.entry.cy     = cy;
    wr.entry.cosine = flip ? -cl_x : cl_x;
    wr.entry.sine   = cl_y;
    wr.entry.inv_x  = sat_x ? INV_MAX : quo_x;
    wr.entry.inv_y  = sat_y ? INV_MAX : quo_y;
    wr.entry.height = ht;
    case (state)
      L_IDLE: begin
        if (start) begin
          state_next = L_SQUARE;
        end
      end
      L_SQUARE: state_next = L_SETUP;
      L_SETUP:  state_next = L_ITER;
      L_ITER: begin
        if (cnt == 5'(DIV_STEPS - 1)) begin
          state_next = L_WRITE;
        end
      end
      L_WRITE: begin
        wr.we      = !skip;
        state_next = L_IDLE;
      end
      default: state_next = L_IDLE;
    endcase
  end

  // Datapath: squares, then setup, then shared iterations.
  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        if (start) begin
          slot  <= idx_ext[IDX_W-1:0];
          skip  <= idx_ext >= (IDX_W + 4)'(NUM_BUMPS);
          cx    <= center_x;
          cy    <= center_y;
          ht    <= peak_height;
          sig_x <= sigma_x;
          sig_y <= sigma_y;
          rot   <= rotation;
        end
      end
      L_SQUARE: begin
        sq_x <= sig_x * sig_x;
        sq_y <= sig_y * sig_y;
      end
      L_SETUP: begin
        sat_x <= (sq_x == 30'd0) || ({10'b0, nf_x} >= {sq_x, 18'b0});
        sat_y <= (sq_y == 30'd0) || ({10'b0, nf_y} >= {sq_y, 18'b0});
        rem_x <= {10'b0, nf_x[37:18]};
        rem_y <= {10'b0, nf_y[37:18]};
        num_x <= nf_x[17:0];
        num_y <= nf_y[17:0];
        cor_x <= CORDIC_K;
        cor_y <= 18'sd0;
        cnt   <= 5'd0;
        if (ang0 > HALF_PI_Q16) begin
          ang  <= PI_Q16 - ang0;
          flip <= 1'b1;
        end else begin
          ang  <= ang0;
          flip <= 1'b0;
        end
      end
      L_ITER: begin
        cnt   <= cnt + 5'd1;
        num_x <= {num_x[16:0], 1'b0};
        num_y <= {num_y[16:0], 1'b0};
        quo_x <= {quo_x[16:0], ge_x};
        quo_y <= {quo_y[16:0], ge_y};
        rem_x <= ge_x ? 30'(trial_x - {1'b0, sq_x}) : trial_x[29:0];
        rem_y <= ge_y ? 30'(trial_y - {1'b0, sq_y}) : trial_y[29:0];
        if (cnt < 5'(CORDIC_STEPS)) begin
          if (ang >= 0) begin
            cor_x <= cor_x - sh_x;
            cor_y <= cor_y + sh_y;
            ang   <= ang - atan_q16(cnt[3:0]);
          end else begin
            cor_x <= cor_x + sh_x;
            cor_y <= cor_y - sh_y;
            ang   <= ang + atan_q16(cnt[3:0]);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/sorg_eval.sv
module sorg_eval import sorg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [15:0]      point_x,
  input  logic [15:0]      point_y,
  output logic [IDX_W-1:0] raddr,
  input  tbl_rd_t          rd,
  output logic             busy,
  output logic             res_valid,
  output eval_res_t        res,
  input  logic             res_take
);

  localparam int HZ    = 3 * HORNER_STEPS;
  localparam int DEPTH = 9 + HZ + 2;
  localparam int ACC_W = 50 + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUMPS - 1);

  eval_state_t state, state_next;

  logic [IDX_W-1:0]   cnt;
  logic [15:0]        px, py;
  logic [DEPTH:0]     vld, lst;

  // Stage 1: offsets.
  logic signed [16:0] s1_dx, s1_dy;
  logic signed [15:0] s1_c, s1_s;
  logic [17:0]        s1_ix, s1_iy;
  logic signed [14:0] s1_h;
  // Stage 2: rotation products.
  logic signed [32:0] s2_xc, s2_ys, s2_xs, s2_yc;
  logic [17:0]        s2_ix, s2_iy;
  logic signed [14:0] s2_h;
  // Stage 3: rotated offsets.
  logic signed [19:0] s3_u, s3_v;
  logic [17:0]        s3_ix, s3_iy;
  logic signed [14:0] s3_h;
  // Stage 4: clamped squares.
  logic [30:0]        s4_u2, s4_v2;
  logic [17:0]        s4_ix, s4_iy;
  logic signed [14:0] s4_h;
  // Stage 5: weighted squares.
  logic [48:0]        s5_tx, s5_ty;
  logic signed [14:0] s5_h;
  // Stage 6: exponent.
  logic [29:0]        s6_e;
  logic               s6_big;
  logic signed [14:0] s6_h;
  // Stage 7: reciprocal product.
  logic [60:0]        s7_pe;
  logic [29:0]        s7_e;
  logic               s7_big;
  logic signed [14:0] s7_h;
  // Stage 8: first remainder.
  logic [4:0]         s8_k;
  logic [29:0]        s8_r;
  logic               s8_big;
  logic signed [14:0] s8_h;
  // Stage 9: corrected reduction.
  logic [4:0]         s9_k;
  logic [29:0]        s9_rq;
  logic               s9_big;
  logic signed [14:0] s9_h;
  // Horner stages.
  logic [29:0]        hz_rq  [HZ];
  logic [4:0]         hz_k   [HZ];
  logic               hz_big [HZ];
  logic signed [14:0] hz_h   [HZ];
  logic [60:0]        hm     [HORNER_STEPS];
  logic [61:0]        hq     [HORNER_STEPS];
  logic [30:0]        hh     [HORNER_STEPS];
  // Exp and term.
  logic [30:0]        ex;
  logic signed [14:0] ex_h;
  logic signed [46:0] term;
  logic signed [ACC_W-1:0] acc;

  logic signed [34:0]       sum_u, sum_v;
  logic signed [39:0]       usq, vsq;
  logic [49:0]              esum;
  logic [29:0]              kl;
  logic                     r_ge;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-31:0] sum_w;

  assign raddr = cnt;

  // Rotation sums with the rounding offset.
  assign sum_u = 35'(s2_xc) - 35'(s2_ys) + 35'sd8192;
  assign sum_v = 35'(s2_xs) + 35'(s2_yc) + 35'sd8192;
  assign usq   = s3_u * s3_u;
  assign vsq   = s3_v * s3_v;
  assign esum  = 50'(s5_tx) + 50'(s5_ty);
  assign kl    = 30'(s7_pe[60:LN2_SHIFT] * LN2_Q26);
  assign r_ge  = s8_r >= LN2_Q26;

  // Rounding and saturation of the finished sum.
  assign rnd   = acc + ACC_W'(64'd1 << 29);
  assign sum_w = rnd[ACC_W-1:30];

  always_comb begin
    res.x = px;
    res.y = py;
    if (sum_w > SUM_MAX) begin
      res.height = 19'(SUM_MAX);
      res.sat    = 1'b1;
    end else if (sum_w < SUM_MIN) begin
      res.height = 19'(SUM_MIN);
      res.sat    = 1'b1;
    end else begin
      res.height = sum_w[18:0];
      res.sat    = 1'b0;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and outputs.
  always_comb begin
    state_next = state;
    busy       = (state != E_IDLE);
    res_valid  = 1'b0;
    case (state)
      E_IDLE: begin
        if (start) begin
          state_next = E_ISSUE;
        end
      end
      E_ISSUE: begin
        if (cnt == LAST_IDX) begin
          state_next = E_DRAIN;
        end
      end
      E_DRAIN: begin
        if (vld[DEPTH] && lst[DEPTH]) begin
          state_next = E_DONE;
        end
      end
      E_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = E_IDLE;
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  // Slot counter, beat tags and accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      lst <= '0;
      cnt <= '0;
    end else begin
      vld <= {vld[DEPTH-1:0], state == E_ISSUE};
      lst <= {lst[DEPTH-1:0], (state == E_ISSUE) && (cnt == LAST_IDX)};
      if (state == E_ISSUE) begin
        cnt <= cnt + IDX_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_IDLE && start) begin
      px  <= point_x;
      py  <= point_y;
      acc <= '0;
    end else if (vld[DEPTH]) begin
      acc <= acc + ACC_W'(term);
    end
  end

  // Per-bump pipeline.
  always_ff @(posedge clk) begin
    s1_dx <= $signed({1'b0, px}) - $signed({1'b0, rd.entry.cx});
    s1_dy <= $signed({1'b0, py}) - $signed({1'b0, rd.entry.cy});
    s1_c  <= rd.entry.cosine;
    s1_s  <= rd.entry.sine;
    s1_ix <= rd.entry.inv_x;
    s1_iy <= rd.entry.inv_y;
    s1_h  <= rd.live ? rd.entry.height : 15'sd0;

    s2_xc <= s1_dx * s1_c;
    s2_ys <= s1_dy * s1_s;
    s2_xs <= s1_dx * s1_s;
    s2_yc <= s1_dy * s1_c;
    s2_ix <= s1_ix;
    s2_iy <= s1_iy;
    s2_h  <= s1_h;

    s3_u  <= sum_u[33:14];
    s3_v  <= sum_v[33:14];
    s3_ix <= s2_ix;
    s3_iy <= s2_iy;
    s3_h  <= s2_h;

    // A square at or past 2^30 already puts the exponent past the limit.
    s4_u2 <= (usq[39:30] != 10'd0) ? ONE_Q30 : {1'b0, usq[29:0]};
    s4_v2 <= (vsq[39:30] != 10'd0) ? ONE_Q30 : {1'b0, vsq[29:0]};
    s4_ix <= s3_ix;
    s4_iy <= s3_iy;
    s4_h  <= s3_h;

    s5_tx <= s4_u2 * s4_ix;
    s5_ty <= s4_v2 * s4_iy;
    s5_h  <= s4_h;

    s6_e   <= esum[29:0];
    s6_big <= esum[49:30] != 20'd0;
    s6_h   <= s5_h;

    s7_pe  <= s6_e * LN2_RECIP;
    s7_e   <= s6_e;
    s7_big <= s6_big;
    s7_h   <= s6_h;

    s8_k   <= s7_pe[60:LN2_SHIFT];
    s8_r   <= s7_e - kl;
    s8_big <= s7_big;
    s8_h   <= s7_h;

    s9_k   <= s8_k + {4'b0, r_ge};
    s9_rq  <= {(r_ge ? 26'(s8_r - LN2_Q26) : s8_r[25:0]), 4'b0};
    s9_big <= s8_big;
    s9_h   <= s8_h;

    // Side data rides along the Horner stages.
    hz_rq[0]  <= s9_rq;
    hz_k[0]   <= s9_k;
    hz_big[0] <= s9_big;
    hz_h[0]   <= s9_h;
    for (int s = 1; s < HZ; s++) begin
      hz_rq[s]  <= hz_rq[s-1];
      hz_k[s]   <= hz_k[s-1];
      hz_big[s] <= hz_big[s-1];
      hz_h[s]   <= hz_h[s-1];
    end

    // Each step: multiply, divide through the reciprocal product, subtract from one.
    hm[0] <= s9_rq * ONE_Q30;
    for (int j = 1; j < HORNER_STEPS; j++) begin
      hm[j] <= hz_rq[3*j-1] * hh[j-1];
    end
    for (int j = 0; j < HORNER_STEPS; j++) begin
      hq[j] <= hm[j][59:30] * HORNER_MUL[j];
      hh[j] <= ONE_Q30 - 31'(hq[j] >> HORNER_SHIFT[j]);
    end

    ex   <= hz_big[HZ-1] ? 31'd0 : (hh[HORNER_STEPS-1] >> hz_k[HZ-1]);
    ex_h <= hz_h[HZ-1];

    term <= ex_h * $signed({1'b0, ex});
  end

endmodule

// File: design/sum_of_rotated_gaussians_top.sv
// Channel  Direction  Handshake             Beat contents
// in       into       in_valid / in_stall   op, bump_index, center, sigma, height, rotation, point
// out      out of     out_valid / out_stall out_x, out_y, surface_height, saturated
//
// A load beat runs a squaring state, a setup state, then an iteration state in which
// the two inverse dividers and the sine/cosine rotation share one iteration counter,
// then a write state. An evaluate beat makes one table read per bump into a rotate,
// square and exponential pipeline, then gives the summed result.
// One beat is in work at a time; in_stall is high while either unit is busy.
// Reset clears the per-slot loaded bits, so unloaded slots add nothing; the table
// memory itself is not cleared. A stalled result holds in the output register and
// the next beat is still taken; an evaluate that finishes meanwhile waits for it.
module sum_of_rotated_gaussians_top import sorg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [3:0]         bump_index,
  input  logic [15:0]        center_x,
  input  logic [15:0]        center_y,
  input  logic [14:0]        sigma_x,
  input  logic [14:0]        sigma_y,
  input  logic signed [14:0] peak_height,
  input  logic [14:0]        rotation,
  input  logic [15:0]        point_x,
  input  logic [15:0]        point_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_x,
  output logic [15:0]        out_y,
  output logic signed [18:0] surface_height,
  output logic               saturated
);

  logic             accept;
  logic             load_busy, eval_busy;
  tbl_wr_t          wr;
  tbl_rd_t          rd;
  logic [IDX_W-1:0] raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [NUM_BUMPS-1:0] loaded;
  logic             live_q;
  logic             res_valid, res_take;
  eval_res_t        res;

  assign in_stall = load_busy | eval_busy;
  assign accept   = in_valid & ~in_stall;

  sorg_load u_load (
    .clk         (clk),
    .rst         (rst),
    .start       (accept && (op_t'(op) == OP_LOAD)),
    .bump_index  (bump_index),
    .center_x    (center_x),
    .center_y    (center_y),
    .sigma_x     (sigma_x),
    .sigma_y     (sigma_y),
    .peak_height (peak_height),
    .rotation    (rotation),
    .busy        (load_busy),
    .wr          (wr)
  );

  sorg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BUMPS)
  ) u_table (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.entry),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Loaded bits, read in step with the table memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
      live_q <= 1'b0;
    end else begin
      if (wr.we) begin
        loaded[wr.addr] <= 1'b1;
      end
      live_q <= loaded[raddr];
    end
  end

  // A slot never loaded reads as an all-zero entry.
  assign rd = live_q ? {1'b1, rdata} : '0;

  sorg_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && (op_t'(op) == OP_EVAL)),
    .point_x   (point_x),
    .point_y   (point_y),
    .raddr     (raddr),
    .rd        (rd),
    .busy      (eval_busy),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Output register.
  assign res_take = res_valid & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_x          <= res.x;
      out_y          <= res.y;
      surface_height <= res.height;
      saturated      <= res.sat;
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sorg_pkg::*;

  // One input beat as queued for the driver; drain_first holds it until all results are in.
  typedef struct {
    op_t                op;
    logic [3:0]         idx;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [14:0]        sx;
    logic [14:0]        sy;
    logic signed [14:0] hgt;
    logic [14:0]        rot;
    logic [15:0]        px;
    logic [15:0]        py;
    bit                 drain_first;
  } beat_t;

  typedef struct {
    logic [15:0]        x;
    logic [15:0]        y;
    logic signed [18:0] h;
    logic               sat;
  } surface_t;

  const int ATAN_Q16[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
  const longint LN2_FIX = 46516320;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = 1'b0;
  logic [3:0]         bump_index = '0;
  logic [15:0]        center_x = '0;
  logic [15:0]        center_y = '0;
  logic [14:0]        sigma_x = '0;
  logic [14:0]        sigma_y = '0;
  logic signed [14:0] peak_height = '0;
  logic [14:0]        rotation = '0;
  logic [15:0]        point_x = '0;
  logic [15:0]        point_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_x;
  logic [15:0]        out_y;
  logic signed [18:0] surface_height;
  logic               saturated;

  sum_of_rotated_gaussians_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the bump table.
  longint tbl_cx[16], tbl_cy[16], tbl_cos[16], tbl_sin[16];
  longint tbl_invx[16], tbl_invy[16], tbl_hgt[16];

  beat_t    pending_beats[$];
  surface_t expected_surfaces[$];
  int       errors = 0;
  int       loads_done = 0;
  int       evals_done = 0;
  int       sent = 0;
  int       tx_idle = 27;
  int       rx_idle = 55;
  int       hold_cycles = 0;
  bit       hold_used = 1'b0;
  bit       finished = 1'b0;
  logic [15:0] gen_cx[16], gen_cy[16];

  // Rotation-step sine and cosine in Q1.14, angles folded about pi/2.
  function automatic void sin_cos(input int rot, output longint c, output longint s);
    int a, x, y, dx, dy;
    bit flip;
    a = rot << 3;
    flip = 1'b0;
    x = 9949;
    y = 0;
    if (a > 102944) begin
      a = 205887 - a;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= ATAN_Q16[i];
      end else begin
        x += dx; y -= dy; a += ATAN_Q16[i];
      end
    end
    if (x > 16384) x = 16384;
    if (x < -16384) x = -16384;
    if (y > 16384) y = 16384;
    if (y < -16384) y = -16384;
    c = flip ? -x : x;
    s = y;
  endfunction

  // 1/(2 sigma^2) in Q4.14, saturating.
  function automatic longint half_inv_square(input longint sigma);
    longint sq, q;
    sq = sigma * sigma;
    if (sq == 0) return 262143;
    q = ((64'sd1 <<< 37) + sq / 2) / sq;
    return (q > 262143) ? 262143 : q;
  endfunction

  // exp(-e) in Q.30 for e in Q.26.
  function automatic longint exp_decay(input longint e);
    longint k, r, h;
    if (e >= (64'sd16 <<< 26)) return 0;
    k = e / LN2_FIX;
    r = (e - k * LN2_FIX) <<< 4;
    h = 64'sd1 <<< 30;
    for (int n = 6; n >= 1; n--)
      h = (64'sd1 <<< 30) - ((r * h) >>> 30) / n;
    return h >>> k;
  endfunction

  // Applies one accepted beat to the shadow table or queues the surface it yields.
  task automatic predict_beat(input beat_t b);
    longint dx, dy, u, v, e, acc, sum;
    surface_t res;
    if (b.op == OP_LOAD) begin
      tbl_cx[b.idx] = b.cx;
      tbl_cy[b.idx] = b.cy;
      tbl_invx[b.idx] = half_inv_square(b.sx);
      tbl_invy[b.idx] = half_inv_square(b.sy);
      tbl_hgt[b.idx] = b.hgt;
      sin_cos(b.rot, tbl_cos[b.idx], tbl_sin[b.idx]);
      loads_done++;
    end else begin
      acc = 0;
      for (int i = 0; i < 16; i++) begin
        dx = longint'(b.px) - tbl_cx[i];
        dy = longint'(b.py) - tbl_cy[i];
        u = (dx * tbl_cos[i] - dy * tbl_sin[i] + 8192) >>> 14;
        v = (dx * tbl_sin[i] + dy * tbl_cos[i] + 8192) >>> 14;
        e = u * u * tbl_invx[i] + v * v * tbl_invy[i];
        acc += tbl_hgt[i] * exp_decay(e);
      end
      sum = (acc + (64'sd1 <<< 29)) >>> 30;
      res.sat = 1'b0;
      if (sum > SUM_MAX) begin
        sum = SUM_MAX; res.sat = 1'b1;
      end
      if (sum < SUM_MIN) begin
        sum = SUM_MIN; res.sat = 1'b1;
      end
      res.x = b.px;
      res.y = b.py;
      res.h = 19'(sum);
      expected_surfaces.push_back(res);
      evals_done++;
    end
  endtask

  function automatic beat_t load_beat(int idx, int cx, int cy, int sx, int sy, int hgt,
                                      int rot);
    beat_t b;
    b.op = OP_LOAD; b.idx = 4'(idx); b.cx = 16'(cx); b.cy = 16'(cy);
    b.sx = 15'(sx); b.sy = 15'(sy); b.hgt = 15'(hgt); b.rot = 15'(rot);
    b.px = 16'($urandom); b.py = 16'($urandom);
    b.drain_first = 1'b0;
    gen_cx[idx] = 16'(cx);
    gen_cy[idx] = 16'(cy);
    return b;
  endfunction

  function automatic beat_t eval_beat(int px, int py);
    beat_t b;
    b.op = OP_EVAL; b.idx = 4'($urandom); b.cx = 16'($urandom); b.cy = 16'($urandom);
    b.sx = 15'($urandom); b.sy = 15'($urandom); b.hgt = 15'($urandom);
    b.rot = 15'($urandom); b.px = 16'(px); b.py = 16'(py);
    b.drain_first = 1'b0;
    return b;
  endfunction

  // Random beat: some table loads, mostly evaluations near loaded bumps, some noise at full field range.
  function automatic beat_t random_beat();
    int slot, sel;
    sel = $urandom_range(0, 99);
    slot = $urandom_range(0, 15);
    if (sel < 30)
      return load_beat(slot, $urandom_range(0, 65535), $urandom_range(0, 65535),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                                    : $urandom_range(1024, 32767),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                                    : $urandom_range(1024, 32767),
                       $urandom_range(0, 32767),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                                    : $urandom_range(0, 25736));
    if (sel < 85)
      return eval_beat(int'(gen_cx[slot]) + $urandom_range(0, 1200) - 600,
                       int'(gen_cy[slot]) + $urandom_range(0, 1200) - 600);
    return eval_beat($urandom_range(0, 65535), $urandom_range(0, 65535));
  endfunction

  // Driver: offers the next beat when the line is free, idling at random.
  always @(posedge clk) begin
    beat_t b;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_beat(pending_beats.pop_front());
        sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() == 0 || $urandom_range(0, 99) < tx_idle ||
            (pending_beats[0].drain_first && expected_surfaces.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          b = pending_beats[0];
          pending_beats[0].drain_first = 1'b0;
          in_valid    <= 1'b1;
          op          <= b.op;
          bump_index  <= b.idx;
          center_x    <= b.cx;
          center_y    <= b.cy;
          sigma_x     <= b.sx;
          sigma_y     <= b.sy;
          peak_height <= b.hgt;
          rotation    <= b.rot;
          point_x     <= b.px;
          point_y     <= b.py;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off so the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (!hold_used && evals_done >= 300) begin
      hold_used <= 1'b1;
      hold_cycles <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle);
    end
  end

  // Monitor: each result beat is checked against the oldest expected surface.
  always @(posedge clk) begin
    surface_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_surfaces.size() == 0) begin
        $display("%t: unexpected result x=%h y=%h h=%0d", $time, out_x, out_y,
                 surface_height);
        errors++;
      end else begin
        w = expected_surfaces.pop_front();
        if (out_x !== w.x) begin
          $display("%t: out_x expected %h actual %h", $time, w.x, out_x); errors++;
        end
        if (out_y !== w.y) begin
          $display("%t: out_y expected %h actual %h", $time, w.y, out_y); errors++;
        end
        if (surface_height !== w.h) begin
          $display("%t: surface_height expected %0d actual %0d", $time, w.h,
                   surface_height);
          errors++;
        end
        if (saturated !== w.sat) begin
          $display("%t: saturated expected %b actual %b", $time, w.sat, saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    beat_t b;
    for (int i = 0; i < 16; i++) begin
      gen_cx[i] = 16'd0;
      gen_cy[i] = 16'd0;
      tbl_cx[i] = 0; tbl_cy[i] = 0; tbl_cos[i] = 0; tbl_sin[i] = 0;
      tbl_invx[i] = 0; tbl_invy[i] = 0; tbl_hgt[i] = 0;
    end

    // Directed: empty table, field extremes, zero and tiny sigma, angles past pi.
    pending_beats.push_back(eval_beat(0, 0));
    pending_beats.push_back(load_beat(0, 32000, 32000, 4096, 4096, 16383, 0));
    pending_beats.push_back(eval_beat(32000, 32000));
    pending_beats.push_back(load_beat(15, 65535, 65535, 32767, 1024, -16384, 25736));
    pending_beats.push_back(eval_beat(65535, 65535));
    pending_beats.push_back(eval_beat(65400, 65500));
    pending_beats.push_back(load_beat(1, 0, 0, 0, 1, 12000, 12868));
    pending_beats.push_back(eval_beat(0, 0));
    pending_beats.push_back(eval_beat(2, 1));
    pending_beats.push_back(load_beat(2, 1000, 1000, 20000, 3000, -9000, 32767));
    pending_beats.push_back(eval_beat(1100, 950));
    pending_beats.push_back(load_beat(3, 1000, 1000, 8000, 2000, 5000, 12869));
    pending_beats.push_back(eval_beat(1000, 1000));
    pending_beats.push_back(eval_beat(1200, 1150));
    for (int i = 4; i < 15; i++)
      pending_beats.push_back(load_beat(i, 500, 500, 32767, 32767, 16383, 6000 * (i & 3)));
    pending_beats.push_back(eval_beat(500, 500));
    pending_beats.push_back(load_beat(0, 500, 500, 32767, 32767, 16383, 100));
    pending_beats.push_back(load_beat(15, 500, 500, 32767, 32767, 16383, 100));
    pending_beats.push_back(eval_beat(500, 500));
    for (int i = 4; i < 15; i++)
      pending_beats.push_back(load_beat(i, 500, 500, 32767, 32767, -16384, 25000));
    pending_beats.push_back(eval_beat(500, 500));
    pending_beats.push_back(eval_beat(520, 480));

    for (int i = 0; i < 1100; i++) begin
      b = random_beat();
      if (i == 200 || i == 800) b.drain_first = 1'b1;
      pending_beats.push_back(b);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Idle pattern changes with progress through the beats.
    while (pending_beats.size() > 0 || in_valid) begin
      @(posedge clk);
      if (sent > 800) begin
        tx_idle = 0; rx_idle = 0;
      end else if (sent > 450) begin
        tx_idle = 55; rx_idle = 27;
      end
    end
    while (expected_surfaces.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);

    finished = 1'b1;
    $display("Covered %0d table loads and %0d surface evaluations under random stalls,",
             loads_done, evals_done);
    $display("including a long output hold-off and drained pauses.");
    if (errors == 0 && expected_surfaces.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    if (!finished) begin
      $display("Timeout with %0d results outstanding", expected_surfaces.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
